@@ rtl/assembler_token_lexer_macros.svh @@
// Assertion helpers for the checker file.
`ifndef ASSEMBLER_TOKEN_LEXER_MACROS_SVH
`define ASSEMBLER_TOKEN_LEXER_MACROS_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define ATL_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define ATL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/atl_pkg.sv @@
`timescale 1ns / 1ps

package atl_pkg;

   localparam int OUT_POS_W = 24;
   localparam int OUT_ROW_W = 20;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // byte classes
   localparam logic [2:0] CLS_END     = 3'd0;
   localparam logic [2:0] CLS_NEWLINE = 3'd1;
   localparam logic [2:0] CLS_SPACE   = 3'd2;
   localparam logic [2:0] CLS_HASH    = 3'd3;
   localparam logic [2:0] CLS_PUNCT   = 3'd4;
   localparam logic [2:0] CLS_QUOTE   = 3'd5;
   localparam logic [2:0] CLS_PREFIX  = 3'd6;
   localparam logic [2:0] CLS_OTHER   = 3'd7;

   // punctuation sub codes, in token kind order
   localparam logic [1:0] PUNCT_LPAREN = 2'd0;
   localparam logic [1:0] PUNCT_RPAREN = 2'd1;
   localparam logic [1:0] PUNCT_COMMA  = 2'd2;
   localparam logic [1:0] PUNCT_COLON  = 2'd3;

   // pending token kinds, also the prefix sub codes
   localparam logic [1:0] PEND_IDENT     = 2'd0;
   localparam logic [1:0] PEND_DIRECTIVE = 2'd1;
   localparam logic [1:0] PEND_REGISTER  = 2'd2;
   localparam logic [1:0] PEND_IMMEDIATE = 2'd3;

   localparam logic [3:0] KIND_LPAREN = 4'd4;
   localparam logic [3:0] KIND_RPAREN = 4'd5;
   localparam logic [3:0] KIND_COMMA  = 4'd6;
   localparam logic [3:0] KIND_COLON  = 4'd7;
   localparam logic [3:0] KIND_STRING = 4'd8;
   localparam logic [3:0] KIND_ERROR  = 4'd9;

   localparam logic [1:0] ERR_NONE         = 2'd0;
   localparam logic [1:0] ERR_END_IN_STR   = 2'd1;
   localparam logic [1:0] ERR_PREFIX_IN_TK = 2'd2;

   typedef struct packed {
      logic [2:0] cls;
      logic [1:0] sub;
   } item_type;

   typedef struct packed {
      logic [3:0]           kind;
      logic [OUT_POS_W-1:0] start;
      logic [OUT_POS_W-1:0] length;
      logic [OUT_ROW_W-1:0] line;
      logic [1:0]           err;
      logic                 last;
   } rec_type;

endpackage

@@ rtl/assembler_token_lexer.sv @@
`timescale 1ns / 1ps
// An accepted request is queued, then the back end registers its records onto rsp.
// One byte per cycle while the queue is not full; the lexer back end takes one queued byte
// a cycle, but holds a byte with records while the output or its overflow slot is busy.
// A four-entry byte queue between classifier and lexer absorbs those stalls.
// Reset (synchronous, active high): empty queue and output, idle, offset 0, row 1.
module assembler_token_lexer #(
   parameter int POSITION_BITS = 24,
   parameter int ROW_BITS      = 20
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_byte,
   input  logic        req_end_of_input,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_token_kind,
   output logic [23:0] rsp_text_start,
   output logic [23:0] rsp_text_length,
   output logic [19:0] rsp_line_number,
   output logic [1:0]  rsp_error_code,
   output logic        rsp_last_of_run
);
   import atl_pkg::*;

   item_type push_item;
   item_type head_item;
   logic     push;
   logic     pop;
   logic     head_valid;
   logic     queue_full;
   rec_type  rsp_rec;

   atl_front u_front (
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_char_byte    (req_char_byte),
      .req_end_of_input (req_end_of_input),
      .queue_full       (queue_full),
      .push             (push),
      .item             (push_item)
   );

   atl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item),
      .full       (queue_full)
   );

   atl_back #(
      .POSITION_BITS (POSITION_BITS),
      .ROW_BITS      (ROW_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (head_valid),
      .item       (head_item),
      .item_pop   (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_rec    (rsp_rec)
   );

   assign rsp_token_kind  = rsp_rec.kind;
   assign rsp_text_start  = rsp_rec.start;
   assign rsp_text_length = rsp_rec.length;
   assign rsp_line_number = rsp_rec.line;
   assign rsp_error_code  = rsp_rec.err;
   assign rsp_last_of_run = rsp_rec.last;

endmodule

@@ rtl/atl_front.sv @@
`timescale 1ns / 1ps

module atl_front (
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_char_byte,
   input  logic              req_end_of_input,
   input  logic              queue_full,
   output logic              push,
   output atl_pkg::item_type item
);
   import atl_pkg::*;

   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      item.cls = CLS_OTHER;
      item.sub = PEND_IDENT;
      if (req_end_of_input || req_char_byte == 8'h00) begin
         item.cls = CLS_END;
      end else if (req_char_byte == 8'h0a) begin
         item.cls = CLS_NEWLINE;
      end else if (req_char_byte inside {8'h20, 8'h09, 8'h0d}) begin
         item.cls = CLS_SPACE;
      end else if (req_char_byte == "#") begin
         item.cls = CLS_HASH;
      end else if (req_char_byte == "\"") begin
         item.cls = CLS_QUOTE;
      end else begin
         case (req_char_byte)
            "(": begin
               item.cls = CLS_PUNCT;
               item.sub = PUNCT_LPAREN;
            end
            ")": begin
               item.cls = CLS_PUNCT;
               item.sub = PUNCT_RPAREN;
            end
            ",": begin
               item.cls = CLS_PUNCT;
               item.sub = PUNCT_COMMA;
            end
            ":": begin
               item.cls = CLS_PUNCT;
               item.sub = PUNCT_COLON;
            end
            ".": begin
               item.cls = CLS_PREFIX;
               item.sub = PEND_DIRECTIVE;
            end
            "%": begin
               item.cls = CLS_PREFIX;
               item.sub = PEND_REGISTER;
            end
            "$": begin
               item.cls = CLS_PREFIX;
               item.sub = PEND_IMMEDIATE;
            end
            default: begin
               item.cls = CLS_OTHER;
               item.sub = PEND_IDENT;
            end
         endcase
      end
   end

endmodule

@@ rtl/atl_queue.sv @@
`timescale 1ns / 1ps

module atl_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  atl_pkg::item_type push_item,
   input  logic              pop,
   output logic              head_valid,
   output atl_pkg::item_type head_item,
   output logic              full
);
   import atl_pkg::*;

   item_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign head_valid = count_ff != '0;
   assign full       = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign head_item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ rtl/atl_back.sv @@
`timescale 1ns / 1ps

module atl_back #(
   parameter int POSITION_BITS = 24,
   parameter int ROW_BITS      = 20
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             item_valid,
   input  atl_pkg::item_type item,
   output logic             item_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output atl_pkg::rec_type rsp_rec
);
   import atl_pkg::*;

   localparam logic [2:0] MODE_IDLE    = 3'd0;
   localparam logic [2:0] MODE_PENDING = 3'd1;
   localparam logic [2:0] MODE_COMMENT = 3'd2;
   localparam logic [2:0] MODE_STRING  = 3'd3;
   localparam logic [2:0] MODE_HALTED  = 3'd4;

   logic [2:0]               mode_ff, mode_in;
   logic [1:0]               kind_ff, kind_in;
   logic [POSITION_BITS-1:0] begin_ff, begin_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [ROW_BITS-1:0]      row_ff, row_in;

   logic                     out_valid_ff, out_valid_in;
   rec_type                  out_rec_ff, out_rec_in;
   logic                     second_valid_ff, second_valid_in;
   rec_type                  second_rec_ff, second_rec_in;

   logic [POSITION_BITS-1:0] pos_next;
   logic [POSITION_BITS-1:0] pend_len;
   logic [ROW_BITS-1:0]      row_inc;

   logic [2:0]               idle_mode;
   logic [1:0]               idle_kind;
   logic [POSITION_BITS-1:0] idle_begin;
   logic [ROW_BITS-1:0]      idle_row;
   logic                     idle_emit;
   rec_type                  idle_rec;

   rec_type                  pend_rec;
   rec_type                  rec0, rec1;
   logic [1:0]               n_rec;
   logic                     out_free;
   logic                     proc;

   function automatic rec_type make_rec(
      input logic [3:0]               kind,
      input logic [POSITION_BITS-1:0] start,
      input logic [POSITION_BITS-1:0] length,
      input logic [ROW_BITS-1:0]      row,
      input logic [1:0]               err
   );
      rec_type r;
      r.kind   = kind;
      r.start  = OUT_POS_W'(start);
      r.length = OUT_POS_W'(length);
      r.line   = OUT_ROW_W'(row);
      r.err    = err;
      r.last   = 1'b0;
      return r;
   endfunction

   assign pos_next = pos_ff + 1'b1;
   assign pend_len = pos_ff - begin_ff;
   // saturate at all ones
   assign row_inc  = (row_ff == '1) ? row_ff : row_ff + 1'b1;
   assign pend_rec = make_rec({2'b00, kind_ff}, begin_ff, pend_len, row_ff, ERR_NONE);

   // what a byte does when no token is pending
   always_comb begin
      idle_mode  = MODE_IDLE;
      idle_kind  = kind_ff;
      idle_begin = begin_ff;
      idle_row   = row_ff;
      idle_emit  = 1'b0;
      idle_rec   = make_rec(KIND_LPAREN + {2'b00, item.sub}, pos_ff,
                            POSITION_BITS'(1), row_ff, ERR_NONE);
      case (item.cls)
         CLS_HASH: begin
            idle_mode = MODE_COMMENT;
         end
         CLS_PUNCT: begin
            idle_emit = 1'b1;
         end
         CLS_QUOTE: begin
            idle_mode  = MODE_STRING;
            idle_begin = pos_next;
         end
         CLS_PREFIX: begin
            idle_mode  = MODE_PENDING;
            idle_kind  = item.sub;
            idle_begin = pos_next;
         end
         CLS_NEWLINE: begin
            idle_row = row_inc;
         end
         CLS_OTHER: begin
            idle_mode  = MODE_PENDING;
            idle_kind  = PEND_IDENT;
            idle_begin = pos_ff;
         end
         default: begin
            idle_mode = MODE_IDLE;
         end
      endcase
   end

   always_comb begin
      mode_in  = mode_ff;
      kind_in  = kind_ff;
      begin_in = begin_ff;
      pos_in   = pos_next;
      row_in   = row_ff;
      rec0     = pend_rec;
      rec1     = idle_rec;
      n_rec    = 2'd0;
      if (item.cls == CLS_END) begin
         if (mode_ff == MODE_PENDING) begin
            n_rec = 2'd1;
         end else if (mode_ff == MODE_STRING) begin
            rec0  = make_rec(KIND_ERROR, begin_ff, pend_len, row_ff, ERR_END_IN_STR);
            n_rec = 2'd1;
         end
         // start a fresh stream
         mode_in  = MODE_IDLE;
         kind_in  = PEND_IDENT;
         begin_in = '0;
         pos_in   = '0;
         row_in   = ROW_BITS'(1);
      end else begin
         case (mode_ff)
            MODE_IDLE: begin
               mode_in  = idle_mode;
               kind_in  = idle_kind;
               begin_in = idle_begin;
               row_in   = idle_row;
               if (idle_emit) begin
                  rec0  = idle_rec;
                  n_rec = 2'd1;
               end
            end
            MODE_PENDING: begin
               if (item.cls == CLS_NEWLINE || item.cls == CLS_SPACE ||
                   item.cls == CLS_HASH || item.cls == CLS_PUNCT) begin
                  mode_in  = idle_mode;
                  kind_in  = idle_kind;
                  begin_in = idle_begin;
                  row_in   = idle_row;
                  n_rec    = idle_emit ? 2'd2 : 2'd1;
               end else if (item.cls == CLS_QUOTE) begin
                  // drop the pending token, open a string
                  mode_in  = MODE_STRING;
                  begin_in = pos_next;
               end else if (item.cls == CLS_PREFIX) begin
                  rec0    = make_rec(KIND_ERROR, begin_ff, pend_len, row_ff,
                                     ERR_PREFIX_IN_TK);
                  n_rec   = 2'd1;
                  mode_in = MODE_HALTED;
               end
            end
            MODE_COMMENT: begin
               if (item.cls == CLS_NEWLINE) begin
                  mode_in = MODE_IDLE;
                  row_in  = row_inc;
               end
            end
            MODE_STRING: begin
               if (item.cls == CLS_QUOTE) begin
                  rec0    = make_rec(KIND_STRING, begin_ff, pend_len, row_ff, ERR_NONE);
                  n_rec   = 2'd1;
                  mode_in = MODE_IDLE;
               end
            end
            default: begin
               mode_in = MODE_HALTED;
            end
         endcase
      end
      rec0.last = (n_rec == 2'd1);
      rec1.last = 1'b1;
   end

   assign out_free = !out_valid_ff || rsp_ready;
   assign proc     = item_valid &&
                     (n_rec == 2'd0 || (out_free && !second_valid_ff));
   assign item_pop = proc;

   // output register plus one overflow slot for the second record
   always_comb begin
      out_valid_in    = out_valid_ff;
      out_rec_in      = out_rec_ff;
      second_valid_in = second_valid_ff;
      second_rec_in   = second_rec_ff;
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (second_valid_ff) begin
         if (out_free) begin
            out_valid_in    = 1'b1;
            out_rec_in      = second_rec_ff;
            second_valid_in = 1'b0;
         end
      end else if (proc && n_rec != 2'd0) begin
         out_valid_in = 1'b1;
         out_rec_in   = rec0;
         if (n_rec == 2'd2) begin
            second_valid_in = 1'b1;
            second_rec_in   = rec1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_IDLE;
         kind_ff         <= PEND_IDENT;
         begin_ff        <= '0;
         pos_ff          <= '0;
         row_ff          <= ROW_BITS'(1);
         out_valid_ff    <= 1'b0;
         second_valid_ff <= 1'b0;
      end else begin
         if (proc) begin
            mode_ff  <= mode_in;
            kind_ff  <= kind_in;
            begin_ff <= begin_in;
            pos_ff   <= pos_in;
            row_ff   <= row_in;
         end
         out_valid_ff    <= out_valid_in;
         second_valid_ff <= second_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_rec_ff    <= out_rec_in;
      second_rec_ff <= second_rec_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_rec   = out_rec_ff;

endmodule

@@ rtl/atl_checker.sv @@
`timescale 1ns / 1ps
`include "assembler_token_lexer_macros.svh"

module atl_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [3:0]  rsp_token_kind,
   input logic [23:0] rsp_text_start,
   input logic [23:0] rsp_text_length,
   input logic [19:0] rsp_line_number,
   input logic [1:0]  rsp_error_code,
   input logic        rsp_last_of_run
);
   import atl_pkg::*;

   logic [74:0] rsp_payload;
   logic        rsp_is_punct;

   assign rsp_payload  = {rsp_token_kind, rsp_text_start, rsp_text_length,
                          rsp_line_number, rsp_error_code, rsp_last_of_run};
   assign rsp_is_punct = rsp_token_kind == KIND_LPAREN || rsp_token_kind == KIND_RPAREN ||
                         rsp_token_kind == KIND_COMMA || rsp_token_kind == KIND_COLON;

   `ATL_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "stalled record changed")
   `ATL_ASSERT_NOW(a_err_kind, rsp_valid, (rsp_token_kind == KIND_ERROR) == (rsp_error_code != ERR_NONE), "error code and error kind disagree")
   `ATL_ASSERT_NOW(a_row_nonzero, rsp_valid, rsp_line_number != 20'd0, "row count reached zero")
   `ATL_ASSERT_NOW(a_punct_len, rsp_valid && rsp_is_punct, rsp_text_length == 24'd1, "punctuation record not one byte long")

endmodule

bind assembler_token_lexer atl_checker u_atl_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_token_kind  (rsp_token_kind),
   .rsp_text_start  (rsp_text_start),
   .rsp_text_length (rsp_text_length),
   .rsp_line_number (rsp_line_number),
   .rsp_error_code  (rsp_error_code),
   .rsp_last_of_run (rsp_last_of_run)
);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
   import atl_pkg::*;

   localparam int IDLE_LIMIT   = 5000;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 20;
   localparam int REPORT_LIMIT = 10;

   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_LF      = 8'h0A;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_QUOTE   = 8'h22;
   localparam logic [7:0] CH_HASH    = 8'h23;
   localparam logic [7:0] CH_DOLLAR  = 8'h24;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_COMMA   = 8'h2C;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_COLON   = 8'h3A;

   localparam logic [2:0] LEX_IDLE    = 3'd0;
   localparam logic [2:0] LEX_PENDING = 3'd1;
   localparam logic [2:0] LEX_COMMENT = 3'd2;
   localparam logic [2:0] LEX_STRING  = 3'd3;
   localparam logic [2:0] LEX_HALTED  = 3'd4;

   logic        clock;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic [7:0]  req_char_byte    = 8'h00;
   logic        req_end_of_input = 1'b0;
   logic        rsp_ready        = 1'b0;
   logic        req_ready;
   logic        rsp_valid;
   logic [3:0]  rsp_token_kind;
   logic [23:0] rsp_text_start;
   logic [23:0] rsp_text_length;
   logic [19:0] rsp_line_number;
   logic [1:0]  rsp_error_code;
   logic        rsp_last_of_run;

   assembler_token_lexer DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_char_byte    (req_char_byte),
      .req_end_of_input (req_end_of_input),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_text_start   (rsp_text_start),
      .rsp_text_length  (rsp_text_length),
      .rsp_line_number  (rsp_line_number),
      .rsp_error_code   (rsp_error_code),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   rec_type expected_records[$];
   int      mismatch_count = 0;
   int      sent_count     = 0;

   // sender and receiver pacing
   int gap_max    = 0;
   int ready_pct  = 100;
   int burst_left = 0;
   int hold_seq   = 0;

   // token state tracked alongside the block
   logic [2:0]           mode_q       = LEX_IDLE;
   logic [1:0]           pend_kind_q  = PEND_IDENT;
   logic [OUT_POS_W-1:0] text_begin_q = '0;
   logic [OUT_POS_W-1:0] offset_q     = '0;
   logic [OUT_ROW_W-1:0] row_q        = OUT_ROW_W'(1);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit is_space(input logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
   endfunction

   function automatic bit is_delim(input logic [7:0] c);
      return is_space(c) || c == CH_HASH || c == CH_COLON || c == CH_COMMA ||
             c == CH_LPAREN || c == CH_RPAREN;
   endfunction

   function automatic bit is_prefix(input logic [7:0] c);
      return c == CH_DOT || c == CH_PERCENT || c == CH_DOLLAR;
   endfunction

   function automatic logic [1:0] prefix_to_kind(input logic [7:0] c);
      if (c == CH_DOT) return PEND_DIRECTIVE;
      if (c == CH_PERCENT) return PEND_REGISTER;
      return PEND_IMMEDIATE;
   endfunction

   function automatic logic [3:0] punct_to_kind(input logic [7:0] c);
      if (c == CH_LPAREN) return KIND_LPAREN;
      if (c == CH_RPAREN) return KIND_RPAREN;
      if (c == CH_COMMA) return KIND_COMMA;
      return KIND_COLON;
   endfunction

   function automatic bit is_punct(input logic [7:0] c);
      return c == CH_LPAREN || c == CH_RPAREN || c == CH_COMMA || c == CH_COLON;
   endfunction

   function void push_record(input logic [3:0] kind, input logic [OUT_POS_W-1:0] start,
                             input logic [OUT_POS_W-1:0] length, input logic [1:0] err);
      rec_type r;
      r.kind   = kind;
      r.start  = start;
      r.length = length;
      r.line   = row_q;
      r.err    = err;
      r.last   = 1'b0;
      expected_records.insert(expected_records.size(), r);
   endfunction

   function void advance_row();
      if (row_q != '1) row_q = row_q + 1'b1;
   endfunction

   function void reset_stream();
      mode_q       = LEX_IDLE;
      pend_kind_q  = PEND_IDENT;
      text_begin_q = '0;
      offset_q     = '0;
      row_q        = OUT_ROW_W'(1);
   endfunction

   function void start_from_idle(input logic [7:0] c);
      if (c == CH_HASH) begin
         mode_q = LEX_COMMENT;
      end else if (is_punct(c)) begin
         push_record(punct_to_kind(c), offset_q, OUT_POS_W'(1), ERR_NONE);
      end else if (c == CH_QUOTE) begin
         mode_q       = LEX_STRING;
         text_begin_q = offset_q + 1'b1;
      end else if (is_prefix(c)) begin
         mode_q       = LEX_PENDING;
         pend_kind_q  = prefix_to_kind(c);
         text_begin_q = offset_q + 1'b1;
      end else if (c == CH_LF) begin
         advance_row();
      end else if (!is_space(c)) begin
         mode_q       = LEX_PENDING;
         pend_kind_q  = PEND_IDENT;
         text_begin_q = offset_q;
      end
   endfunction

   function void predict_tokens(input logic [7:0] c, input logic eoi);
      int                   base;
      logic [OUT_POS_W-1:0] span;
      base = expected_records.size();
      span = offset_q - text_begin_q;
      if (eoi || c == CH_NUL) begin
         if (mode_q == LEX_PENDING)
            push_record({2'b00, pend_kind_q}, text_begin_q, span, ERR_NONE);
         else if (mode_q == LEX_STRING)
            push_record(KIND_ERROR, text_begin_q, span, ERR_END_IN_STR);
         reset_stream();
      end else begin
         case (mode_q)
            LEX_IDLE: start_from_idle(c);
            LEX_PENDING: begin
               if (is_delim(c)) begin
                  push_record({2'b00, pend_kind_q}, text_begin_q, span, ERR_NONE);
                  mode_q = LEX_IDLE;
                  start_from_idle(c);
               end else if (c == CH_QUOTE) begin
                  // drop the pending token, open a string
                  mode_q       = LEX_STRING;
                  text_begin_q = offset_q + 1'b1;
               end else if (is_prefix(c)) begin
                  push_record(KIND_ERROR, text_begin_q, span, ERR_PREFIX_IN_TK);
                  mode_q = LEX_HALTED;
               end
            end
            LEX_COMMENT: begin
               if (c == CH_LF) begin
                  mode_q = LEX_IDLE;
                  advance_row();
               end
            end
            LEX_STRING: begin
               if (c == CH_QUOTE) begin
                  push_record(KIND_STRING, text_begin_q, span, ERR_NONE);
                  mode_q = LEX_IDLE;
               end
            end
            default: mode_q = LEX_HALTED;
         endcase
         offset_q = offset_q + 1'b1;
      end
      if (expected_records.size() > base)
         expected_records[expected_records.size() - 1].last = 1'b1;
   endfunction

   function void note_failure(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) $display("%s", msg);
   endfunction

   // Send one request; valid stays high between back-to-back requests of a burst.
   task automatic send_byte(input logic [7:0] c, input logic eoi);
      int gap;
      if (burst_left == 0) begin
         gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      req_valid        <= 1'b1;
      req_char_byte    <= c;
      req_end_of_input <= eoi;
      do @(posedge clock); while (!req_ready);
      predict_tokens(c, eoi);
      sent_count++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
   endtask

   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(1, 255)); while (is_delim(b) || is_prefix(b) || b == CH_QUOTE);
      return b;
   endfunction

   function automatic logic [7:0] pick_space();
      case ($urandom_range(0, 3))
         0: return CH_SPACE;
         1: return CH_TAB;
         2: return CH_CR;
         default: return CH_LF;
      endcase
   endfunction

   function automatic logic [7:0] pick_prefix();
      case ($urandom_range(0, 2))
         0: return CH_DOT;
         1: return CH_PERCENT;
         default: return CH_DOLLAR;
      endcase
   endfunction

   function automatic logic [7:0] pick_punct();
      case ($urandom_range(0, 3))
         0: return CH_LPAREN;
         1: return CH_RPAREN;
         2: return CH_COMMA;
         default: return CH_COLON;
      endcase
   endfunction

   function automatic logic [7:0] pick_lexical();
      case ($urandom_range(0, 5))
         0: return pick_space();
         1: return pick_prefix();
         2: return pick_punct();
         3: return CH_QUOTE;
         4: return CH_HASH;
         default: return plain_byte();
      endcase
   endfunction

   task automatic send_token();
      int         pick;
      int         n;
      logic [7:0] b;
      pick = $urandom_range(0, 99);
      if (pick < 28) begin
         n = $urandom_range(1, 6);
         repeat (n) send_byte(plain_byte(), 1'b0);
      end else if (pick < 43) begin
         send_byte(pick_prefix(), 1'b0);
         n = $urandom_range(0, 4);
         repeat (n) send_byte(plain_byte(), 1'b0);
      end else if (pick < 58) begin
         send_byte(pick_punct(), 1'b0);
      end else if (pick < 68) begin
         send_byte(CH_QUOTE, 1'b0);
         n = $urandom_range(0, 6);
         repeat (n) begin
            do b = 8'($urandom_range(1, 255)); while (b == CH_QUOTE);
            send_byte(b, 1'b0);
         end
         send_byte(CH_QUOTE, 1'b0);
      end else if (pick < 75) begin
         send_byte(CH_HASH, 1'b0);
         n = $urandom_range(0, 5);
         repeat (n) begin
            do b = 8'($urandom_range(1, 255)); while (b == CH_LF);
            send_byte(b, 1'b0);
         end
         send_byte(CH_LF, 1'b0);
      end else if (pick < 90) begin
         send_byte(pick_space(), 1'b0);
      end else if (pick < 96) begin
         send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end else begin
         send_byte(8'($urandom_range(0, 255)), 1'b1);
      end
   endtask

   task automatic test_directed();
      gap_max   = 2;
      ready_pct = 80;
      send_text("x:.d,%(");
      send_text("$1)");
      send_text("\"a\"");
      send_text("#c\n");
      send_byte(CH_TAB, 1'b0);
      send_byte(CH_CR, 1'b0);
      // prefix inside a token halts until the end request
      send_text("a.bz");
      send_byte(8'hFF, 1'b1);
      // quote inside a token, then end inside the string
      send_text("q\"w");
      send_byte(CH_NUL, 1'b1);
      // zero byte flushes like an end request
      send_byte(8'hFF, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(CH_NUL, 1'b0);
   endtask

   task automatic test_programs(input int items, input int gap, input int pct);
      int target;
      gap_max   = gap;
      ready_pct = pct;
      target    = sent_count + items;
      while (sent_count < target) send_token();
      send_byte(8'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic test_noise(input int items);
      gap_max   = 3;
      ready_pct = 70;
      repeat (items) begin
         if ($urandom_range(0, 1) == 1)
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
         else
            send_byte(pick_lexical(), $urandom_range(0, 15) == 0);
      end
      send_byte(8'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic test_input_stall();
      gap_max   = 0;
      ready_pct = 100;
      hold_seq <= hold_seq + 1;
      // each comma yields two records, so the queue fills quickly
      repeat (30) send_text("a,");
      send_byte(CH_NUL, 1'b1);
   endtask

   // receiver: random stall runs plus one long hold-off on request
   initial begin
      int stall_left;
      int hold_left;
      int hold_seen;
      stall_left = 0;
      hold_left  = 0;
      hold_seen  = 0;
      forever begin
         @(posedge clock);
         if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 99) >= ready_pct) stall_left = $urandom_range(1, 6);
         end
      end
   end

   always @(posedge clock) begin
      rec_type got;
      rec_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got.kind   = rsp_token_kind;
         got.start  = rsp_text_start;
         got.length = rsp_text_length;
         got.line   = rsp_line_number;
         got.err    = rsp_error_code;
         got.last   = rsp_last_of_run;
         if (expected_records.size() == 0) begin
            note_failure($sformatf("unexpected record: kind %0d start %0d len %0d line %0d",
                                   got.kind, got.start, got.length, got.line));
         end else begin
            want = expected_records.pop_front();
            if (got !== want)
               note_failure({
                  $sformatf("record mismatch: exp kind %0d start %0d len %0d line %0d",
                            want.kind, want.start, want.length, want.line),
                  $sformatf(" err %0d last %0b,", want.err, want.last),
                  $sformatf(" got kind %0d start %0d len %0d line %0d err %0d last %0b",
                            got.kind, got.start, got.length, got.line, got.err,
                            got.last)});
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
         if (quiet >= IDLE_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_programs(450, 0, 100);
      test_input_stall();
      test_programs(450, 4, 75);
      test_noise(200);
      test_programs(450, 8, 40);
      req_valid <= 1'b0;
      ready_pct = 100;
      while (expected_records.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_records.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/atl_pkg.sv
rtl/atl_front.sv
rtl/atl_queue.sv
rtl/atl_back.sv
rtl/assembler_token_lexer.sv
rtl/atl_checker.sv
tb/testbench.sv
